// ===== rtl/smc_pkg.sv =====
// Shared types and constants for the substring match counter.
package smc_pkg;

	// Fixed widths of the register file and the result words.
	localparam int PAT_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int LINE_W     = 20;
	localparam int TOTAL_W    = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	// Text constants and saturation limits.
	localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
	localparam logic [LINE_W-1:0]  LINE_MAX     = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

	// Pattern as seen by the comparator, with its length already clamped.
	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [LEN_W-1:0]          len;
	} cfg_t;

	// One text byte leaving the input register and entering the result register.
	typedef struct packed {
		logic       fire;
		logic [7:0] data;
		logic       last;
	} step_t;

endpackage

// ===== rtl/smc_cfg.sv =====
// Configuration registers and pattern length clamping.
module smc_cfg #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output smc_pkg::cfg_t                   cfg
);
	import smc_pkg::*;

	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [LEN_W-1:0]      pattern_length_q;

	// Register writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero length counts as one, a length beyond the window as the window.
	always_comb begin
		cfg.pattern = {pattern_high_q, pattern_low_q};
		if (pattern_length_q == '0) begin
			cfg.len = LEN_W'(1);
		end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
			cfg.len = LEN_W'(MAX_PATTERN);
		end else begin
			cfg.len = pattern_length_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.len != '0 && cfg.len <= LEN_W'(MAX_PATTERN))
		else $error("clamped pattern length out of range");

endmodule

// ===== rtl/smc_window.sv =====
// Window of recent text bytes, parallel pattern compare and match spacing.
module smc_window #(
	parameter int MAX_PATTERN = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  smc_pkg::step_t step,
	input  smc_pkg::cfg_t  cfg,
	output logic           hit
);
	import smc_pkg::*;

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic [7:0]             win_q   [MAX_PATTERN];
	logic [7:0]             win_new [MAX_PATTERN];
	logic [CNT_W-1:0]       since_q;
	logic [CNT_W-1:0]       since_inc;
	logic [MAX_PATTERN-1:0] byte_ok;

	// Window after this byte is shifted in; the newest byte sits at index 0.
	always_comb begin
		win_new[0] = step.data;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_new[k] = win_q[k-1];
		end
	end

	// Pattern byte i lines up with window position len-1-i; unused bytes pass.
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
		logic [LEN_W-1:0] pos;
		assign pos = cfg.len - LEN_W'(i + 1);
		assign byte_ok[i] = (LEN_W'(i) >= cfg.len) ||
			(win_new[pos[IDX_W-1:0]] == cfg.pattern[i]);
	end

	// Matches may not overlap: a full pattern length must follow the last one.
	assign since_inc = (since_q < CNT_W'(MAX_PATTERN)) ? since_q + CNT_W'(1) : since_q;
	assign hit       = (&byte_ok) && (LEN_W'(since_inc) >= cfg.len);

	// State advances with each byte and clears after the last byte of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= '0;
			end
			since_q <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					win_q[k] <= '0;
				end
				since_q <= '0;
			end else begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					win_q[k] <= win_new[k];
				end
				since_q <= hit ? '0 : since_inc;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && hit && !step.last |=> since_q == '0)
		else $error("spacing counter not restarted after a match");

endmodule

// ===== rtl/smc_count.sv =====
// Line and match counters with saturation.
module smc_count (
	input  logic                         clk,
	input  logic                         arst_n,
	input  smc_pkg::step_t               step,
	input  logic                         hit,
	output logic [smc_pkg::LINE_W-1:0]   line_number,
	output logic [smc_pkg::TOTAL_W-1:0]  match_total
);
	import smc_pkg::*;

	logic [LINE_W-1:0]  line_q;
	logic [TOTAL_W-1:0] match_q;
	logic [TOTAL_W-1:0] match_next;

	// The result carries the line before a newline is counted and the total after this match.
	assign match_next  = (hit && match_q != TOTAL_MAX) ? match_q + TOTAL_W'(1) : match_q;
	assign line_number = line_q;
	assign match_total = match_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= LINE_W'(1);
			match_q <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				line_q  <= LINE_W'(1);
				match_q <= '0;
			end else begin
				match_q <= match_next;
				if (step.data == NEWLINE_BYTE && line_q != LINE_MAX) begin
					line_q <= line_q + LINE_W'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && step.last |=> line_q == LINE_W'(1) && match_q == '0)
		else $error("counters not cleared after the last byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

endmodule

// ===== rtl/substring_match_counter_core.sv =====
// Top level of the streaming substring match counter.
//
//  Channel  | Handshake             | Word
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | text_byte, final_byte
//  result   | out_valid / out_ready | match_found, line_number, match_total, end_of_text
//  config   | cfg_write             | cfg_index, cfg_data
//
// One word is taken per cycle unless both registers are full and the result stalls.
// The window compare and both counters sit between the input and result registers.
// Reset empties both registers and the window, resets the counters and sets the pattern
// to one zero byte. A stalled result holds while the input register takes one more word.
module substring_match_counter_core #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            final_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            match_found,
	output logic [smc_pkg::LINE_W-1:0]      line_number,
	output logic [smc_pkg::TOTAL_W-1:0]     match_total,
	output logic                            end_of_text
);
	import smc_pkg::*;

	cfg_t               cfg;
	step_t              step;
	logic               hit;
	logic [LINE_W-1:0]  line_now;
	logic [TOTAL_W-1:0] total_now;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               valid_s2;
	logic               found_s2;
	logic [LINE_W-1:0]  line_s2;
	logic [TOTAL_W-1:0] total_s2;
	logic               last_s2;
	logic               advance;

	// A word moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign step.fire = advance;
	assign step.data = byte_s1;
	assign step.last = last_s1;

	smc_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smc_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg),
		.hit    (hit)
	);

	smc_count u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.hit         (hit),
		.line_number (line_now),
		.match_total (total_now)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= final_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_s2 <= hit;
			line_s2  <= line_now;
			total_s2 <= total_now;
			last_s2  <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign match_found = found_s2;
	assign line_number = line_s2;
	assign match_total = total_s2;
	assign end_of_text = last_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input held off while a register is free");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_found |-> match_total != '0)
		else $error("match reported with a zero total");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable({match_found, line_number, match_total, end_of_text}))
		else $error("stalled result word changed");

endmodule
